@@ rtl/stpa_pkg.sv @@
`default_nettype none
package stpa_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int NUM_PORTS = 4;
    localparam int MAX_GUARDED = 4;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int REAP_W = 5;
    localparam int REAP_MAX = (1 << REAP_W) - 1;

    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_ADD = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;
    localparam logic [1:0] FUNC_CLEAR = 2'd3;

    localparam logic [3:0] VER_V4 = 4'd4;
    localparam logic [3:0] VER_V6 = 4'd6;

    localparam logic [1:0] ADD_OK = 2'd0;
    localparam logic [1:0] ADD_BAD_VER = 2'd1;
    localparam logic [1:0] ADD_FULL = 2'd2;

    localparam logic [2:0] CFG_PORT_COUNT = 3'd0;
    localparam logic [2:0] CFG_PORT_A = 3'd1;
    localparam logic [2:0] CFG_PORT_B = 3'd2;
    localparam logic [2:0] CFG_PORT_C = 3'd3;
    localparam logic [2:0] CFG_PORT_D = 3'd4;
    localparam logic [2:0] CFG_TIMEOUT = 3'd5;

    typedef struct packed {
        logic [NUM_PORTS-1:0][15:0] port;
        logic [NUM_PORTS-1:0]       used;
    } guard_cfg_t;

    typedef struct packed {
        logic        lookup;
        logic        add;
        logic        reap;
        logic        clear;
        logic        v6;
        logic [15:0] port;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic match;
        logic stale;
        logic claim;
    } cell_stat_t;

    // first guarded port in use that equals p
    function automatic logic [NUM_PORTS-1:0] guard_sel(input logic [15:0] p,
                                                       input guard_cfg_t g);
        logic                 found;
        logic [NUM_PORTS-1:0] sel;
        found = 1'b0;
        sel = '0;
        for (int i = 0; i < NUM_PORTS; i++)
        begin
            if (!found && g.used[i] && g.port[i] == p)
            begin
                sel[i] = 1'b1;
                found = 1'b1;
            end
        end
        return sel;
    endfunction

endpackage
`default_nettype wire

@@ rtl/stpa_cell.sv @@
`default_nettype none
module stpa_cell (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire stpa_pkg::cmd_t                     cmd,
    input  wire stpa_pkg::guard_cfg_t               gcfg,
    input  wire logic [stpa_pkg::NUM_PORTS-1:0]     port_stale,
    input  wire logic                               free_in,
    output logic                                    free_out,
    output stpa_pkg::cell_stat_t                    stat
);

    logic        valid_reg;
    logic        valid_next;
    logic        is_v6_reg;
    logic [15:0] port_reg;
    logic [63:0] addr_high_reg;
    logic [63:0] addr_low_reg;

    logic [stpa_pkg::NUM_PORTS-1:0] gsel;
    logic match;
    logic stale;
    logic claim;

    always_comb
    begin
        gsel = stpa_pkg::guard_sel(port_reg, gcfg);
        match = cmd.lookup && valid_reg && (is_v6_reg == cmd.v6) && (port_reg == cmd.port)
                && (addr_high_reg == cmd.addr_high) && (addr_low_reg == cmd.addr_low);
        stale = valid_reg && (|(gsel & port_stale));
        claim = !valid_reg && !free_in;
        free_out = free_in || !valid_reg;
        valid_next = valid_reg;
        if (cmd.clear)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.reap && stale)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.add && claim)
        begin
            valid_next = 1'b1;
        end
        stat.valid = valid_reg;
        stat.match = match;
        stat.stale = stale;
        stat.claim = claim;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add && claim)
        begin
            is_v6_reg <= cmd.v6;
            port_reg <= cmd.port;
            addr_high_reg <= cmd.addr_high;
            addr_low_reg <= cmd.addr_low;
        end
    end

endmodule
`default_nettype wire

@@ rtl/session_table_with_port_aging_core.sv @@
// flow: an accepted transaction is held and executed across the row of table cells
// once the output register is free, and its result is then registered there
// stall: a new transaction is not accepted while one is held, so in_stall stays
// high from acceptance until the held transaction has executed
// reset: table empty, port stamps and time zero, sweep countdown and timeout 1000
`default_nettype none
module session_table_with_port_aging_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [3:0]  ip_version,
    input  wire logic [15:0] dest_port,
    input  wire logic [63:0] addr_high,
    input  wire logic [63:0] addr_low,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             hit,
    output logic [1:0]       add_status,
    output logic             reap_ran,
    output logic [4:0]       reaped_count
);

    localparam int NP = stpa_pkg::NUM_PORTS;
    localparam int TD = stpa_pkg::TABLE_DEPTH;

    // configuration
    logic [2:0]  port_count_reg;
    logic [stpa_pkg::MAX_GUARDED-1:0][15:0] guarded_reg;
    logic [31:0] timeout_reg;
    logic [31:0] tmo_eff;
    stpa_pkg::guard_cfg_t gcfg;

    // time keeping
    logic [NP-1:0][31:0] stamp_reg;
    logic [31:0] now_reg;
    logic [31:0] countdown_reg;

    // held transaction
    logic        busy_reg;
    logic [1:0]  func_reg;
    logic        ver_ok_reg;
    logic        v6_reg;
    logic [15:0] port_reg;
    logic [63:0] addr_high_reg;
    logic [63:0] addr_low_reg;
    logic [NP-1:0] item_guard_reg;
    logic [NP-1:0] port_stale_reg;
    logic [NP-1:0] port_stale_next;

    // result
    logic        out_valid_reg;
    logic        hit_reg;
    logic [1:0]  add_status_reg;
    logic        reap_ran_reg;
    logic [4:0]  reaped_count_reg;

    logic        in_accept;
    logic        exec_go;
    logic        is_tick;
    logic        do_reap;
    stpa_pkg::cmd_t cmd;
    stpa_pkg::cell_stat_t [TD-1:0] stat;
    logic [TD:0] free_chain;
    logic [TD-1:0] match_vec;
    logic [TD-1:0] stale_vec;
    logic [TD-1:0] claim_vec;
    logic [TD-1:0] valid_vec;
    logic        any_hit;
    logic        full;
    logic [stpa_pkg::CNT_W-1:0] reap_cnt;
    logic [4:0]  reap_sat;
    logic [1:0]  status_next;

    assign cfg_ready = 1'b1;
    assign in_stall = busy_reg;
    assign in_accept = in_valid && !in_stall;
    assign exec_go = busy_reg && (!out_valid_reg || !out_stall);
    assign tmo_eff = (timeout_reg == 32'd0) ? 32'd1 : timeout_reg;

    always_comb
    begin
        for (int i = 0; i < NP; i++)
        begin
            gcfg.port[i] = guarded_reg[i];
            gcfg.used[i] = (port_count_reg > 3'(i));
        end
        for (int i = 0; i < NP; i++)
        begin
            port_stale_next[i] = ((now_reg + 32'd1) - stamp_reg[i]) >= tmo_eff;
        end
    end

    always_comb
    begin
        is_tick = (func_reg == stpa_pkg::FUNC_TICK);
        do_reap = exec_go && is_tick && (countdown_reg <= 32'd1);
        cmd.lookup = exec_go && (func_reg == stpa_pkg::FUNC_LOOKUP) && ver_ok_reg;
        cmd.add = exec_go && (func_reg == stpa_pkg::FUNC_ADD) && ver_ok_reg;
        cmd.reap = do_reap;
        cmd.clear = exec_go && (func_reg == stpa_pkg::FUNC_CLEAR);
        cmd.v6 = v6_reg;
        cmd.port = port_reg;
        cmd.addr_high = addr_high_reg;
        cmd.addr_low = addr_low_reg;
    end

    assign free_chain[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < TD; gi++)
        begin : g_cell
            stpa_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .gcfg       (gcfg),
                .port_stale (port_stale_reg),
                .free_in    (free_chain[gi]),
                .free_out   (free_chain[gi+1]),
                .stat       (stat[gi])
            );
            assign match_vec[gi] = stat[gi].match;
            assign stale_vec[gi] = stat[gi].stale;
            assign claim_vec[gi] = stat[gi].claim;
            assign valid_vec[gi] = stat[gi].valid;
        end
    endgenerate

    always_comb
    begin
        any_hit = |match_vec;
        full = !free_chain[TD];
        reap_cnt = stpa_pkg::CNT_W'($countones(stale_vec));
        if (32'(reap_cnt) > 32'(stpa_pkg::REAP_MAX))
        begin
            reap_sat = 5'(stpa_pkg::REAP_MAX);
        end
        else
        begin
            reap_sat = 5'(reap_cnt);
        end
        status_next = stpa_pkg::ADD_OK;
        if (func_reg == stpa_pkg::FUNC_ADD)
        begin
            if (!ver_ok_reg)
            begin
                status_next = stpa_pkg::ADD_BAD_VER;
            end
            else if (full)
            begin
                status_next = stpa_pkg::ADD_FULL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_count_reg <= 3'd0;
            guarded_reg <= '0;
            timeout_reg <= stpa_pkg::TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                stpa_pkg::CFG_PORT_COUNT: port_count_reg <= cfg_data[2:0];
                stpa_pkg::CFG_PORT_A:     guarded_reg[0] <= cfg_data[15:0];
                stpa_pkg::CFG_PORT_B:     guarded_reg[1] <= cfg_data[15:0];
                stpa_pkg::CFG_PORT_C:     guarded_reg[2] <= cfg_data[15:0];
                stpa_pkg::CFG_PORT_D:     guarded_reg[3] <= cfg_data[15:0];
                stpa_pkg::CFG_TIMEOUT:    timeout_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            now_reg <= 32'd0;
            countdown_reg <= stpa_pkg::TIMEOUT_RESET;
            stamp_reg <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (exec_go)
            begin
                busy_reg <= 1'b0;
            end

            if (exec_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (exec_go && is_tick)
            begin
                now_reg <= now_reg + 32'd1;
                if (countdown_reg <= 32'd1)
                begin
                    countdown_reg <= tmo_eff;
                end
                else
                begin
                    countdown_reg <= countdown_reg - 32'd1;
                end
            end

            if (cmd.lookup && any_hit)
            begin
                for (int i = 0; i < NP; i++)
                begin
                    if (item_guard_reg[i])
                    begin
                        stamp_reg[i] <= now_reg;
                    end
                end
            end
        end
    end

    // payload and result registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg <= func;
            ver_ok_reg <= (ip_version == stpa_pkg::VER_V4) || (ip_version == stpa_pkg::VER_V6);
            v6_reg <= (ip_version == stpa_pkg::VER_V6);
            port_reg <= dest_port;
            addr_high_reg <= (ip_version == stpa_pkg::VER_V6) ? addr_high : 64'd0;
            addr_low_reg <= (ip_version == stpa_pkg::VER_V6) ? addr_low
                                                             : {32'd0, addr_low[31:0]};
            item_guard_reg <= stpa_pkg::guard_sel(dest_port, gcfg);
            port_stale_reg <= port_stale_next;
        end
        if (exec_go)
        begin
            hit_reg <= cmd.lookup && any_hit;
            add_status_reg <= status_next;
            reap_ran_reg <= do_reap;
            reaped_count_reg <= do_reap ? reap_sat : 5'd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit = hit_reg;
    assign add_status = add_status_reg;
    assign reap_ran = reap_ran_reg;
    assign reaped_count = reaped_count_reg;

    a_claim_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(claim_vec))
        else $error("more than one free cell claimed");

    a_guard_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> $onehot0(item_guard_reg))
        else $error("transaction port maps to several guarded ports");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (valid_vec == '0))
        else $error("table not empty after clear");

    a_full_no_store: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.add && full) |=> ($stable(valid_vec) && add_status_reg == stpa_pkg::ADD_FULL))
        else $error("add into full table changed the table");

    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(hit_reg && reap_ran_reg))
        else $error("lookup hit and sweep in the same result");

endmodule
`default_nettype wire
